### design/foic_pkg.sv
// ----------------------------------------------------------------------------
// foic_pkg: shared types and tables of the fixed-order interrupt controller
// Holds the transaction payload types, the register state type, the command
// codes, the register map and the fixed scan order table.
// ----------------------------------------------------------------------------
package foic_pkg;

  // Command codes of an input transaction.
  typedef enum logic [1:0] {
    CMD_RAISE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_FLAGS = 2'd3
  } cmd_e;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0] command;
    logic [4:0] source_number;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       from_cpu;
    logic [7:0] cpu_flags;
    logic       shift_prefix;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_request;
    logic [4:0] irq_id;
  } out_item_t;

  localparam int NumPri   = 3;
  localparam int NumGroup = 4;
  localparam int NumSlots = 27;

  // Architectural register state.
  typedef struct packed {
    logic [NumPri-1:0][7:0]   pri;
    logic [NumGroup-1:0][7:0] ena;
    logic [NumGroup-1:0][7:0] act;
    logic                     master;
  } state_t;

  // Register map.
  localparam logic [7:0] AddrPriFirst = 8'h20;
  localparam logic [7:0] AddrPriLast  = 8'h22;
  localparam logic [7:0] AddrEnaFirst = 8'h23;
  localparam logic [7:0] AddrEnaLast  = 8'h26;
  localparam logic [7:0] AddrActFirst = 8'h27;
  localparam logic [7:0] AddrActLast  = 8'h2A;

  // Highest source number that an event can raise.
  localparam logic [4:0] RaiseMax = 5'h1C;

  // Bits 7:6 of the flag byte both set mask interrupts.
  localparam logic [7:0] FlagMask = 8'hC0;

  // Per-group masks used on read and on direct store.
  localparam logic [NumGroup-1:0][7:0] GroupMask = {8'hF7, 8'hFF, 8'h3F, 8'hFF};
  localparam logic [NumPri-1:0][7:0]   PriReadMask = {8'h03, 8'hFF, 8'hFF};

  // Scan order table: vector, priority register, priority field, group, bit.
  localparam logic [NumSlots-1:0][4:0] SlotVec = {
    5'h1F, 5'h1E, 5'h1D, 5'h1C, 5'h1B, 5'h1A, 5'h19, 5'h18, 5'h17,
    5'h16, 5'h15, 5'h14, 5'h13, 5'h10, 5'h0F, 5'h0E, 5'h0D, 5'h0C,
    5'h0B, 5'h0A, 5'h09, 5'h08, 5'h07, 5'h06, 5'h05, 5'h04, 5'h03};
  localparam logic [NumSlots-1:0][1:0] SlotPri = {
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
  localparam logic [NumSlots-1:0][7:0] SlotPriMask = {
    8'h03, 8'h03, 8'h03, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h0C,
    8'h0C, 8'h0C, 8'h30, 8'h30, 8'h03, 8'h03, 8'hC0, 8'hC0, 8'hC0,
    8'hC0, 8'h03, 8'h03, 8'h0C, 8'h0C, 8'h30, 8'h30, 8'hC0, 8'hC0};
  localparam logic [NumSlots-1:0][1:0] SlotGroup = {
    2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd1, 2'd1, 2'd3, 2'd3, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
  localparam logic [NumSlots-1:0][7:0] SlotBit = {
    8'h01, 8'h02, 8'h04, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
    8'h40, 8'h80, 8'h01, 8'h02, 8'h40, 8'h80, 8'h04, 8'h08, 8'h10,
    8'h20, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80};

endpackage

### design/foic_regs.sv
// ----------------------------------------------------------------------------
// foic_regs: register file of the interrupt controller
// Holds the priority, enable and active registers and the master enable,
// applies one transaction and tells whether a scan has to run.
// ----------------------------------------------------------------------------
module foic_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  foic_pkg::in_item_t item_i,
  output foic_pkg::state_t   state_o,
  output logic               scan_o,
  output logic [7:0]         read_data_o
);
  import foic_pkg::*;

  state_t     state_q, state_d;
  logic [7:0] off_pri, off_ena, off_act;
  logic [1:0] k_pri, k_ena, k_act;
  logic       in_pri, in_ena, in_act;

  // Address decode.
  assign in_pri  = (item_i.reg_addr >= AddrPriFirst) && (item_i.reg_addr <= AddrPriLast);
  assign in_ena  = (item_i.reg_addr >= AddrEnaFirst) && (item_i.reg_addr <= AddrEnaLast);
  assign in_act  = (item_i.reg_addr >= AddrActFirst) && (item_i.reg_addr <= AddrActLast);
  assign off_pri = item_i.reg_addr - AddrPriFirst;
  assign off_ena = item_i.reg_addr - AddrEnaFirst;
  assign off_act = item_i.reg_addr - AddrActFirst;
  assign k_pri   = off_pri[1:0];
  assign k_ena   = off_ena[1:0];
  assign k_act   = off_act[1:0];

  // Next state, read data and scan request for the current transaction.
  always_comb begin
    state_d     = state_q;
    scan_o      = 1'b0;
    read_data_o = 8'h00;
    if (fire_i) begin
      case (cmd_e'(item_i.command))
        CMD_RAISE: begin
          // Sources without a table entry or above the event range set nothing.
          for (int i = 0; i < NumSlots; i++) begin
            if ((SlotVec[i] == item_i.source_number) &&
                (item_i.source_number <= RaiseMax)) begin
              state_d.act[SlotGroup[i]] = state_q.act[SlotGroup[i]] | SlotBit[i];
            end
          end
          scan_o = 1'b1;
        end
        CMD_READ: begin
          if (in_pri) begin
            read_data_o = state_q.pri[k_pri] & PriReadMask[k_pri];
          end else if (in_ena) begin
            read_data_o = state_q.ena[k_ena] & GroupMask[k_ena];
          end else if (in_act) begin
            read_data_o = state_q.act[k_act] & GroupMask[k_act];
          end
        end
        CMD_WRITE: begin
          if (in_pri) begin
            state_d.pri[k_pri] = item_i.write_data;
            scan_o             = 1'b1;
          end else if (in_ena) begin
            state_d.ena[k_ena] = item_i.write_data & GroupMask[k_ena];
            scan_o             = 1'b1;
          end else if (in_act) begin
            // The CPU clears the bits it writes as one; others store directly.
            if (item_i.from_cpu) begin
              state_d.act[k_act] = state_q.act[k_act] & ~item_i.write_data;
            end else begin
              state_d.act[k_act] = item_i.write_data & GroupMask[k_act];
            end
          end
        end
        CMD_FLAGS: begin
          if (item_i.shift_prefix || ((item_i.cpu_flags & FlagMask) == FlagMask)) begin
            state_d.master = 1'b0;
          end else begin
            state_d.master = 1'b1;
            scan_o         = 1'b1;
          end
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{pri: '0, ena: '0, act: '0, master: 1'b1};
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_d;

endmodule

### design/foic_scan.sv
// ----------------------------------------------------------------------------
// foic_scan: fixed-order interrupt scan
// Priority encoder over the scan table: when run_i and master are set,
// reports the first source with a nonzero priority field, enabled and active.
// ----------------------------------------------------------------------------
module foic_scan (
  input  foic_pkg::state_t state_i,
  input  logic             run_i,
  output logic             irq_request_o,
  output logic [4:0]       irq_id_o
);
  import foic_pkg::*;

  logic [NumSlots-1:0] hit;

  // Per-slot match, all slots in parallel.
  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      hit[i] = ((state_i.pri[SlotPri[i]] & SlotPriMask[i]) != 8'h00) &&
               ((state_i.ena[SlotGroup[i]] & SlotBit[i]) != 8'h00) &&
               ((state_i.act[SlotGroup[i]] & SlotBit[i]) != 8'h00);
    end
  end

  // The lowest slot in scan order wins.
  always_comb begin
    irq_request_o = 1'b0;
    irq_id_o      = 5'd0;
    if (run_i && state_i.master) begin
      for (int i = NumSlots - 1; i >= 0; i--) begin
        if (hit[i]) begin
          irq_request_o = 1'b1;
          irq_id_o      = SlotVec[i];
        end
      end
    end
  end

endmodule

### design/fixed_order_interrupt_controller_core.sv
// An accepted transaction is held in the input register, then moves on into
// the result register when that is free; the result register drives the output.
// Throughput: one transaction per cycle while the output does not stall; the
// register update and the scan are combinational, between the input and result registers.
// Reset: the controller registers clear, the master enable sets, both stages empty.
// ----------------------------------------------------------------------------
// fixed_order_interrupt_controller_core: interrupt controller top level
// Input register, register file with fixed-order scan, result register.
// ----------------------------------------------------------------------------
module fixed_order_interrupt_controller_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  foic_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output foic_pkg::out_item_t out_item_o
);
  import foic_pkg::*;

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q, out_d;
  logic      fire, accept;
  state_t    state_next;
  logic      scan_run;

  // The item in the input register moves on when the result register is free.
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  foic_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (in_q),
    .state_o     (state_next),
    .scan_o      (scan_run),
    .read_data_o (out_d.read_data)
  );

  foic_scan u_scan (
    .state_i       (state_next),
    .run_i         (scan_run),
    .irq_request_o (out_d.irq_request),
    .irq_id_o      (out_d.irq_id)
  );

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A reported interrupt always names a mapped source.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.irq_request |-> out_q.irq_id >= 5'h03)
    else $error("irq_request with unmapped source");

  // A read transaction never reports an interrupt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_q.command == CMD_READ) |=> !out_q.irq_request && out_q.irq_id == 5'd0)
    else $error("read transaction produced an interrupt");

  // The input side stalls only when it holds an item that cannot move on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

  // With the master enable clear after the transaction, no interrupt shows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !state_next.master |=> !out_q.irq_request)
    else $error("interrupt reported while master enable is clear");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the fixed-order interrupt controller
// Drives raise, register read, register write and flag update transactions
// through the valid/stall input channel. A scoreboard keeps its own copy of
// the register file, predicts each result, and compares the results taken
// from the output channel in order, field by field. The sender idles and the
// receiver stalls at random, apart from one long stretch at full rate.
// ----------------------------------------------------------------------------
module testbench;
  import foic_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int RandomItems  = 1250;
  localparam int DrainCycles  = 10;

  // One entry of the fixed scan order.
  typedef struct packed {
    logic [4:0] vec;
    logic [1:0] pri_idx;
    logic [7:0] pri_field;
    logic [1:0] grp;
    logic [7:0] src_bit;
  } scan_entry_t;

  localparam scan_entry_t ScanOrder [27] = '{
    {5'h03, 2'd0, 8'hC0, 2'd0, 8'h80}, {5'h04, 2'd0, 8'hC0, 2'd0, 8'h40},
    {5'h05, 2'd0, 8'h30, 2'd0, 8'h20}, {5'h06, 2'd0, 8'h30, 2'd0, 8'h10},
    {5'h07, 2'd0, 8'h0C, 2'd0, 8'h08}, {5'h08, 2'd0, 8'h0C, 2'd0, 8'h04},
    {5'h09, 2'd0, 8'h03, 2'd0, 8'h02}, {5'h0A, 2'd0, 8'h03, 2'd0, 8'h01},
    {5'h0B, 2'd1, 8'hC0, 2'd1, 8'h20}, {5'h0C, 2'd1, 8'hC0, 2'd1, 8'h10},
    {5'h0D, 2'd1, 8'hC0, 2'd1, 8'h08}, {5'h0E, 2'd1, 8'hC0, 2'd1, 8'h04},
    {5'h0F, 2'd2, 8'h03, 2'd3, 8'h80}, {5'h10, 2'd2, 8'h03, 2'd3, 8'h40},
    {5'h13, 2'd1, 8'h30, 2'd1, 8'h02}, {5'h14, 2'd1, 8'h30, 2'd1, 8'h01},
    {5'h15, 2'd1, 8'h0C, 2'd2, 8'h80}, {5'h16, 2'd1, 8'h0C, 2'd2, 8'h40},
    {5'h17, 2'd1, 8'h0C, 2'd2, 8'h20}, {5'h18, 2'd1, 8'h0C, 2'd2, 8'h10},
    {5'h19, 2'd1, 8'h0C, 2'd2, 8'h08}, {5'h1A, 2'd1, 8'h0C, 2'd2, 8'h04},
    {5'h1B, 2'd1, 8'h0C, 2'd2, 8'h02}, {5'h1C, 2'd1, 8'h0C, 2'd2, 8'h01},
    {5'h1D, 2'd1, 8'h03, 2'd3, 8'h04}, {5'h1E, 2'd1, 8'h03, 2'd3, 8'h02},
    {5'h1F, 2'd1, 8'h03, 2'd3, 8'h01}
  };

  // Masks on read and on direct store, per enable/active group.
  localparam logic [7:0] GroupKeep [4] = '{8'hFF, 8'h3F, 8'hFF, 8'hF7};
  localparam logic [7:0] PriReadKeep [3] = '{8'hFF, 8'hFF, 8'h03};
  localparam logic [7:0] MaskingFlags = 8'hC0;
  localparam logic [4:0] HighestRaisable = 5'h1C;

  // Register file predictor and in-order result checker.
  class irq_scoreboard;
    logic [7:0]  pri [3];
    logic [7:0]  ena [4];
    logic [7:0]  act [4];
    logic        master;
    out_item_t   expected_q [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned per_cmd [4];
    int unsigned vectors_seen;

    function new();
      foreach (pri[i]) pri[i] = '0;
      foreach (ena[i]) ena[i] = '0;
      foreach (act[i]) act[i] = '0;
      master = 1'b1;
      errors = 0;
      checked = 0;
      vectors_seen = 0;
      foreach (per_cmd[i]) per_cmd[i] = 0;
    endfunction

    // First enabled, active source whose priority field is nonzero.
    function void scan(output logic req, output logic [4:0] vec);
      req = 1'b0;
      vec = '0;
      if (!master) return;
      foreach (ScanOrder[i]) begin
        if ((pri[ScanOrder[i].pri_idx] & ScanOrder[i].pri_field) != 0 &&
            (ena[ScanOrder[i].grp] & ScanOrder[i].src_bit) != 0 &&
            (act[ScanOrder[i].grp] & ScanOrder[i].src_bit) != 0) begin
          req = 1'b1;
          vec = ScanOrder[i].vec;
          return;
        end
      end
    endfunction

    function void raise(logic [4:0] src);
      if (src > HighestRaisable) return;
      foreach (ScanOrder[i]) begin
        if (ScanOrder[i].vec == src) begin
          act[ScanOrder[i].grp] |= ScanOrder[i].src_bit;
          return;
        end
      end
    endfunction

    // Update the register copy for an accepted transaction and queue its result.
    function void note_input(in_item_t it);
      out_item_t want;
      int        k;
      want = '0;
      per_cmd[it.command]++;
      case (cmd_e'(it.command))
        CMD_RAISE: begin
          raise(it.source_number);
          scan(want.irq_request, want.irq_id);
        end
        CMD_READ: begin
          if (it.reg_addr >= AddrPriFirst && it.reg_addr <= AddrPriLast) begin
            k = int'(it.reg_addr - AddrPriFirst);
            want.read_data = pri[k] & PriReadKeep[k];
          end else if (it.reg_addr >= AddrEnaFirst && it.reg_addr <= AddrEnaLast) begin
            k = int'(it.reg_addr - AddrEnaFirst);
            want.read_data = ena[k] & GroupKeep[k];
          end else if (it.reg_addr >= AddrActFirst && it.reg_addr <= AddrActLast) begin
            k = int'(it.reg_addr - AddrActFirst);
            want.read_data = act[k] & GroupKeep[k];
          end
        end
        CMD_WRITE: begin
          if (it.reg_addr >= AddrPriFirst && it.reg_addr <= AddrPriLast) begin
            pri[it.reg_addr - AddrPriFirst] = it.write_data;
            scan(want.irq_request, want.irq_id);
          end else if (it.reg_addr >= AddrEnaFirst && it.reg_addr <= AddrEnaLast) begin
            k = int'(it.reg_addr - AddrEnaFirst);
            ena[k] = it.write_data & GroupKeep[k];
            scan(want.irq_request, want.irq_id);
          end else if (it.reg_addr >= AddrActFirst && it.reg_addr <= AddrActLast) begin
            // The CPU clears bits written as one; the other writer stores directly.
            k = int'(it.reg_addr - AddrActFirst);
            if (it.from_cpu) act[k] = act[k] & ~it.write_data;
            else act[k] = it.write_data & GroupKeep[k];
          end
        end
        default: begin
          if (it.shift_prefix || (it.cpu_flags & MaskingFlags) == MaskingFlags) begin
            master = 1'b0;
          end else begin
            master = 1'b1;
            scan(want.irq_request, want.irq_id);
          end
        end
      endcase
      if (want.irq_request) vectors_seen++;
      expected_q.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result %h arrived with nothing expected", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.read_data !== want.read_data) begin
        $display("%0t: read_data expected %h, actual %h", $time, want.read_data,
                 got.read_data);
        errors++;
      end
      if (got.irq_request !== want.irq_request) begin
        $display("%0t: irq_request expected %b, actual %b", $time, want.irq_request,
                 got.irq_request);
        errors++;
      end
      if (got.irq_id !== want.irq_id) begin
        $display("%0t: irq_id expected %h, actual %h", $time, want.irq_id,
                 got.irq_id);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  irq_scoreboard sb = new();
  bit            no_idle;
  int unsigned   cycle_count;

  fixed_order_interrupt_controller_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver side: stall at random except during reset and the full-rate stretch.
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !no_idle && ($urandom_range(0, 99) < 37);
    end
  end

  // Record every transaction taken on either channel.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && in_valid_i && !in_stall_o) sb.note_input(in_item_i);
    if (rst_ni === 1'b1 && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic in_item_t make_item(cmd_e cmd, logic [4:0] src, logic [7:0] addr,
                                         logic [7:0] data, logic cpu, logic [7:0] flags,
                                         logic shift);
    in_item_t it;
    it.command       = cmd;
    it.source_number = src;
    it.reg_addr      = addr;
    it.write_data    = data;
    it.from_cpu      = cpu;
    it.cpu_flags     = flags;
    it.shift_prefix  = shift;
    return it;
  endfunction

  // Mostly register-map traffic with unmasking flag updates, some noise.
  function automatic in_item_t random_item();
    in_item_t    it;
    logic [63:0] raw;
    int unsigned roll;
    raw = {$urandom, $urandom};
    it = in_item_t'(raw[$bits(in_item_t)-1:0]);
    roll = $urandom_range(0, 99);
    if (roll < 35) it.command = CMD_RAISE;
    else if (roll < 55) it.command = CMD_READ;
    else if (roll < 88) it.command = CMD_WRITE;
    else it.command = CMD_FLAGS;
    if ($urandom_range(0, 99) < 85) it.reg_addr = 8'($urandom_range(8'h20, 8'h2A));
    if (it.command == CMD_FLAGS && $urandom_range(0, 99) < 75) begin
      it.shift_prefix = 1'b0;
      if (it.cpu_flags[7:6] == 2'b11) it.cpu_flags[7] = 1'b0;
    end
    return it;
  endfunction

  // Present one transaction, with random idle cycles first, until it is taken.
  task automatic send(in_item_t it);
    while (!no_idle && $urandom_range(0, 99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    in_item_t directed [$];
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    no_idle     = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset values, full-scale writes, masks, unmapped sources,
    // unknown addresses, both active-write modes and the masking flag updates.
    directed.push_back(make_item(CMD_READ,  5'd0,  8'h20, 8'h00, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_WRITE, 5'd0,  8'h20, 8'hFF, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_WRITE, 5'd0,  8'h21, 8'hFF, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_WRITE, 5'd0,  8'h22, 8'hFF, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_READ,  5'd0,  8'h22, 8'h00, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_WRITE, 5'd0,  8'h23, 8'hFF, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_WRITE, 5'd0,  8'h24, 8'hFF, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_WRITE, 5'd0,  8'h25, 8'hFF, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_WRITE, 5'd0,  8'h26, 8'hFF, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_READ,  5'd0,  8'h24, 8'h00, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_READ,  5'd0,  8'h26, 8'h00, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_RAISE, 5'd0,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_RAISE, 5'd31, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_RAISE, 5'd28, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_RAISE, 5'd3,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_READ,  5'd0,  8'h27, 8'h00, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_WRITE, 5'd0,  8'h27, 8'hFF, 1'b1, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_WRITE, 5'd0,  8'h2A, 8'hFF, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_READ,  5'd0,  8'h2A, 8'h00, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_RAISE, 5'd17, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_WRITE, 5'd0,  8'h00, 8'hFF, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_READ,  5'd0,  8'hFF, 8'h00, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_FLAGS, 5'd0,  8'h00, 8'h00, 1'b0, 8'h00, 1'b1));
    directed.push_back(make_item(CMD_RAISE, 5'd5,  8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
    directed.push_back(make_item(CMD_FLAGS, 5'd0,  8'h00, 8'h00, 1'b0, 8'hFF, 1'b0));
    directed.push_back(make_item(CMD_FLAGS, 5'd0,  8'h00, 8'h00, 1'b0, 8'h3F, 1'b0));
    foreach (directed[i]) send(directed[i]);
    wait_for_results();

    // Random part, with one stretch at full rate on both sides and one more
    // hold-off until the results catch up.
    for (int n = 0; n < RandomItems; n++) begin
      no_idle = (n >= 500 && n < 800);
      if (n == 900) wait_for_results();
      send(random_item());
    end
    no_idle = 1'b0;
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.outstanding() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.outstanding());
      sb.errors++;
    end
    $display("Checked %0d results: %0d raises, %0d reads, %0d writes, %0d flag updates;",
             sb.checked, sb.per_cmd[CMD_RAISE], sb.per_cmd[CMD_READ],
             sb.per_cmd[CMD_WRITE], sb.per_cmd[CMD_FLAGS]);
    $display("%0d scans reported a pending source, %0d mismatches.", sb.vectors_seen,
             sb.errors);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
